// File: design/radar_afterglow_pixel_decay_core_defines.svh
// ----------------------------------------------------------------------------
// Radar afterglow decay core - assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef RADAR_AFTERGLOW_PIXEL_DECAY_CORE_DEFINES_SVH
`define RADAR_AFTERGLOW_PIXEL_DECAY_CORE_DEFINES_SVH

// Consequent in the same cycle as the antecedent.
`define RAPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rapd port check failed");

// Consequent in the cycle after the antecedent.
`define RAPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rapd port check failed");

`endif

// File: design/rapd_pkg.sv
// ----------------------------------------------------------------------------
// Radar afterglow decay core - package
// Word types, cell layouts, action and register codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rapd_pkg;

	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = 8;

	localparam logic [2:0] ACT_DECAY   = 3'd0;
	localparam logic [2:0] ACT_WR_MAIN = 3'd1;
	localparam logic [2:0] ACT_WR_WIN  = 3'd2;
	localparam logic [2:0] ACT_LD_MAIN = 3'd3;
	localparam logic [2:0] ACT_LD_WIN  = 3'd4;

	localparam logic [2:0] CFG_DECAY_WEIGHT = 3'd0;
	localparam logic [2:0] CFG_MAIN_WIDTH   = 3'd1;
	localparam logic [2:0] CFG_MAIN_HEIGHT  = 3'd2;
	localparam logic [2:0] CFG_WIN_WIDTH    = 3'd3;
	localparam logic [2:0] CFG_WIN_HEIGHT   = 3'd4;
	localparam logic [2:0] CFG_WIN_ENABLE   = 3'd5;
	localparam logic [2:0] CFG_PERSIST      = 3'd6;

	localparam logic [1:0] LAYER_LIMIT = 2'd2;
	localparam logic       PLANE_MAIN  = 1'b0;
	localparam logic       PLANE_WIN   = 1'b1;

	typedef struct packed {
		logic [2:0]  action;
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;
		logic [7:0]  intensity;
		logic [1:0]  layer_level;
		logic        overlay_on;
		logic [31:0] color_value;
	} in_word_t;

	typedef struct packed {
		logic        plane;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [31:0] pixel_color;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [31:0] overlay;
		logic        overlay_on;
		logic [1:0]  layer;
		logic [7:0]  level;
	} main_cell_t;

	typedef struct packed {
		logic [1:0] layer;
		logic [7:0] level;
	} win_cell_t;

endpackage

`default_nettype wire

// File: design/rapd_ram.sv
// ----------------------------------------------------------------------------
// Radar afterglow decay core - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rapd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/radar_afterglow_pixel_decay_core.sv
// ----------------------------------------------------------------------------
// Radar afterglow decay core - top level
// Per-pixel echo intensity and palettes for the main and window displays.
// ----------------------------------------------------------------------------
// One word is in flight at a time. A decay word with persistence enabled keeps the
// core busy through the calculate and emit states until the next acceptance. Its
// results enter the output buffer after the cell memory read and then the palette
// memory read. They enter later if earlier results are still waiting there. A
// cell write or palette load keeps the core busy through the calculate state only.
// Up to two result words (main first, then window) wait in a two-entry output
// buffer, and the next input word is taken while they drain. After reset a
// clearing pass over max(MAIN_DIM*MAIN_DIM, WINDOW_DIM*WINDOW_DIM) entries zeroes
// both cell memories, one entry a cycle. in_ready stays low meanwhile, and
// configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module radar_afterglow_pixel_decay_core #(
	parameter int MAIN_DIM   = 1024,
	parameter int WINDOW_DIM = 512
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire rapd_pkg::in_word_t  in_word,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      rapd_pkg::out_word_t out_word,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [10:0]         cfg_data
);

	import rapd_pkg::*;

	localparam int MAIN_DEPTH = MAIN_DIM * MAIN_DIM;
	localparam int WIN_DEPTH  = WINDOW_DIM * WINDOW_DIM;
	localparam int MA_W       = $clog2(MAIN_DEPTH);
	localparam int WA_W       = $clog2(WIN_DEPTH);
	localparam int CLR_DEPTH  = (MAIN_DEPTH > WIN_DEPTH) ? MAIN_DEPTH : WIN_DEPTH;
	localparam int CLR_W      = $clog2(CLR_DEPTH);
	localparam logic [12:0] MAIN_DIM_C = 13'(MAIN_DIM);
	localparam logic [12:0] WIN_DIM_C  = 13'(WINDOW_DIM);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]       state_q;
	logic [CLR_W-1:0] clr_cnt_q;
	in_word_t         item_q;
	logic [MA_W-1:0]  m_addr_q;
	logic [WA_W-1:0]  w_addr_q;
	logic             in_main_q;
	logic             in_win_q;
	logic             m_emit_q;
	logic             w_emit_q;
	logic [31:0]      m_mask_q;

	logic [7:0]  decay_weight_q;
	logic [10:0] main_width_q;
	logic [10:0] main_height_q;
	logic [9:0]  win_width_q;
	logic [9:0]  win_height_q;
	logic        win_enable_q;
	logic        persist_q;

	out_word_t   slot0_q;
	out_word_t   slot1_q;
	logic [1:0]  cnt_q;

	logic            accept;
	logic [MA_W-1:0] m_addr_d;
	logic [WA_W-1:0] w_addr_d;
	logic            in_main_d;
	logic            in_win_d;

	main_cell_t      m_cell;
	win_cell_t       w_cell;
	logic            m_we;
	logic [MA_W-1:0] m_waddr;
	main_cell_t      m_wdata;
	logic            w_we;
	logic [WA_W-1:0] w_waddr;
	win_cell_t       w_wdata;

	logic        is_decay;
	logic        m_visit;
	logic        w_visit;
	logic [7:0]  m_nv;
	logic [7:0]  w_nv;
	logic        clr_main;
	logic        clr_win;
	logic        pal_re;
	logic [31:0] m_pal;
	logic [31:0] w_pal;
	out_word_t   r_main;
	out_word_t   r_win;
	logic        push;
	logic        pop;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (cnt_q != 2'd0);
	assign out_word  = slot0_q;
	assign pop       = out_valid && out_ready;
	assign push      = (state_q == ST_EMIT) && (cnt_q == 2'd0);

	assign in_main_d = ({3'b0, in_word.pos_x} < MAIN_DIM_C) && ({3'b0, in_word.pos_y} < MAIN_DIM_C);
	assign in_win_d  = ({3'b0, in_word.pos_x} < WIN_DIM_C) && ({3'b0, in_word.pos_y} < WIN_DIM_C);
	assign m_addr_d  = MA_W'({22'b0, in_word.pos_y} * 32'(MAIN_DIM) + {22'b0, in_word.pos_x});
	assign w_addr_d  = WA_W'({22'b0, in_word.pos_y} * 32'(WINDOW_DIM) + {22'b0, in_word.pos_x});

	assign clr_main = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(MAIN_DEPTH));
	assign clr_win  = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(WIN_DEPTH));

	assign is_decay = (item_q.action == ACT_DECAY) && persist_q;
	assign m_visit  = is_decay && in_main_q
		&& ({1'b0, item_q.pos_x} < main_width_q) && ({1'b0, item_q.pos_y} < main_height_q)
		&& (m_cell.level != 8'd0);
	assign w_visit  = is_decay && win_enable_q && in_win_q
		&& (item_q.pos_x < win_width_q) && (item_q.pos_y < win_height_q)
		&& (w_cell.level != 8'd0);
	assign m_nv = (m_cell.level > decay_weight_q) ? (m_cell.level - decay_weight_q) : 8'd0;
	assign w_nv = (w_cell.level > decay_weight_q) ? (w_cell.level - decay_weight_q) : 8'd0;
	assign pal_re = (state_q == ST_CALC);

	always_comb begin
		m_we    = 1'b0;
		m_waddr = m_addr_q;
		m_wdata = '0;
		w_we    = 1'b0;
		w_waddr = w_addr_q;
		w_wdata = '0;
		if (state_q == ST_CLR) begin
			m_we    = clr_main;
			m_waddr = clr_cnt_q[MA_W-1:0];
			w_we    = clr_win;
			w_waddr = clr_cnt_q[WA_W-1:0];
		end else if (state_q == ST_CALC) begin
			if (m_visit) begin
				m_we          = 1'b1;
				m_wdata       = m_cell;
				m_wdata.level = m_nv;
			end else if ((item_q.action == ACT_WR_MAIN) && in_main_q) begin
				m_we               = 1'b1;
				m_wdata.overlay    = item_q.color_value;
				m_wdata.overlay_on = item_q.overlay_on;
				m_wdata.layer      = item_q.layer_level;
				m_wdata.level      = item_q.intensity;
			end
			if (w_visit) begin
				w_we          = 1'b1;
				w_wdata       = w_cell;
				w_wdata.level = w_nv;
			end else if ((item_q.action == ACT_WR_WIN) && in_win_q) begin
				w_we          = 1'b1;
				w_wdata.layer = item_q.layer_level;
				w_wdata.level = item_q.intensity;
			end
		end
	end

	rapd_ram #(.WIDTH($bits(main_cell_t)), .DEPTH(MAIN_DEPTH)) u_main_cells (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (accept),
		.raddr (m_addr_d),
		.rdata (m_cell)
	);

	rapd_ram #(.WIDTH($bits(win_cell_t)), .DEPTH(WIN_DEPTH)) u_win_cells (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (accept),
		.raddr (w_addr_d),
		.rdata (w_cell)
	);

	rapd_ram #(.WIDTH(32), .DEPTH(PAL_DEPTH)) u_main_pal (
		.clk   (clk),
		.we    ((state_q == ST_CALC) && (item_q.action == ACT_LD_MAIN)),
		.waddr (item_q.intensity[PAL_AW-1:0]),
		.wdata (item_q.color_value),
		.re    (pal_re),
		.raddr (m_nv[PAL_AW-1:0]),
		.rdata (m_pal)
	);

	rapd_ram #(.WIDTH(32), .DEPTH(PAL_DEPTH)) u_win_pal (
		.clk   (clk),
		.we    ((state_q == ST_CALC) && (item_q.action == ACT_LD_WIN)),
		.waddr (item_q.intensity[PAL_AW-1:0]),
		.wdata (item_q.color_value),
		.re    (pal_re),
		.raddr (w_nv[PAL_AW-1:0]),
		.rdata (w_pal)
	);

	always_comb begin
		r_main.plane       = PLANE_MAIN;
		r_main.pixel_x     = item_q.pos_x;
		r_main.pixel_y     = item_q.pos_y;
		r_main.pixel_color = m_pal ^ m_mask_q;
		r_main.last        = !w_emit_q;
		r_win.plane        = PLANE_WIN;
		r_win.pixel_x      = item_q.pos_x;
		r_win.pixel_y      = item_q.pos_y;
		r_win.pixel_color  = w_pal;
		r_win.last         = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= is_decay ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= in_word;
			m_addr_q  <= m_addr_d;
			w_addr_q  <= w_addr_d;
			in_main_q <= in_main_d;
			in_win_q  <= in_win_d;
		end
		if (state_q == ST_CALC) begin
			m_emit_q <= m_visit && (m_cell.layer < LAYER_LIMIT);
			w_emit_q <= w_visit && (w_cell.layer < LAYER_LIMIT);
			m_mask_q <= m_cell.overlay_on ? m_cell.overlay : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= {1'b0, m_emit_q} + {1'b0, w_emit_q};
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= m_emit_q ? r_main : r_win;
			slot1_q <= r_win;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_weight_q <= 8'd60;
			main_width_q   <= 11'd1024;
			main_height_q  <= 11'd1024;
			win_width_q    <= 10'd512;
			win_height_q   <= 10'd512;
			win_enable_q   <= 1'b0;
			persist_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DECAY_WEIGHT: decay_weight_q <= cfg_data[7:0];
				CFG_MAIN_WIDTH:   main_width_q   <= cfg_data;
				CFG_MAIN_HEIGHT:  main_height_q  <= cfg_data;
				CFG_WIN_WIDTH:    win_width_q    <= cfg_data[9:0];
				CFG_WIN_HEIGHT:   win_height_q   <= cfg_data[9:0];
				CFG_WIN_ENABLE:   win_enable_q   <= cfg_data[0];
				CFG_PERSIST:      persist_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/rapd_checker.sv
// ----------------------------------------------------------------------------
// Radar afterglow decay core - port checker
// Watches the word channels of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "radar_afterglow_pixel_decay_core_defines.svh"

module rapd_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire rapd_pkg::in_word_t  in_word,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire rapd_pkg::out_word_t out_word
);

	import rapd_pkg::*;

	`RAPD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))
	`RAPD_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)
	`RAPD_ASSERT_NEXT(a_quiet_update, clk, arst_n, in_valid && in_ready && !out_valid && (in_word.action != ACT_DECAY), !out_valid)
	`RAPD_ASSERT_SAME(a_main_first, clk, arst_n, out_valid && !out_word.last, out_word.plane == PLANE_MAIN)
	`RAPD_ASSERT_NEXT(a_pair_follows, clk, arst_n, out_valid && out_ready && !out_word.last, out_valid)

endmodule

bind radar_afterglow_pixel_decay_core rapd_checker u_rapd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire

// File: dv/tb_radar_afterglow_pixel_decay_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar afterglow decay core - testbench
// Streams cell writes, palette loads and decay visits under several register
// settings, predicts every frame-buffer word in a scoreboard and compares each
// one on arrival, with random idling on both sides of the core.
// ----------------------------------------------------------------------------

module tb_radar_afterglow_pixel_decay_core;
	import rapd_pkg::*;

	localparam int MAIN_DIM      = 1024;
	localparam int WINDOW_DIM    = 512;
	localparam int SETTLE_CYCLES = 10;
	localparam int IDLE_PCT      = 38;
	localparam int POOL_SIZE     = 12;
	localparam longint LIMIT_NS  = 64'd32_000_000;
	localparam logic [2:0] ACT_SPARE_TOP = 3'd7;

	class pixel_scoreboard;
		main_cell_t  main_cells[int];
		win_cell_t   win_cells[int];
		logic [31:0] main_pal[PAL_DEPTH];
		logic [31:0] win_pal[PAL_DEPTH];
		bit          main_loaded[PAL_DEPTH];
		bit          win_loaded[PAL_DEPTH];
		logic [7:0]  weight = 8'd60;
		int unsigned main_w = 1024;
		int unsigned main_h = 1024;
		int unsigned win_w  = 512;
		int unsigned win_h  = 512;
		bit          win_en;
		bit          persist;
		out_word_t   pixel_writes[$];
		int          errors;
		int          checked;

		function void set_reg(logic [2:0] idx, logic [10:0] val);
			case (idx)
				CFG_DECAY_WEIGHT: weight = val[7:0];
				CFG_MAIN_WIDTH: main_w = val;
				CFG_MAIN_HEIGHT: main_h = val;
				CFG_WIN_WIDTH: win_w = val[9:0];
				CFG_WIN_HEIGHT: win_h = val[9:0];
				CFG_WIN_ENABLE: win_en = val[0];
				CFG_PERSIST: persist = val[0];
				default: ;
			endcase
		endfunction

		function logic [7:0] faded(logic [7:0] lv);
			return (lv > weight) ? lv - weight : 8'd0;
		endfunction

		// which planes a decay visit touches, whether each redraws, and the new levels
		function void decay_plan(in_word_t w, output bit m_hit, output bit m_draw,
				output logic [7:0] m_lv, output bit w_hit, output bit w_draw,
				output logic [7:0] w_lv);
			int mi;
			int wi;
			main_cell_t mc;
			win_cell_t wc;
			mi = int'(w.pos_y) * MAIN_DIM + int'(w.pos_x);
			wi = int'(w.pos_y) * WINDOW_DIM + int'(w.pos_x);
			mc = main_cells.exists(mi) ? main_cells[mi] : '0;
			wc = win_cells.exists(wi) ? win_cells[wi] : '0;
			m_hit = persist && w.pos_x < MAIN_DIM && w.pos_y < MAIN_DIM && w.pos_x < main_w
				&& w.pos_y < main_h && mc.level != 8'd0;
			m_draw = m_hit && mc.layer < LAYER_LIMIT;
			m_lv = faded(mc.level);
			w_hit = persist && win_en && w.pos_x < WINDOW_DIM && w.pos_y < WINDOW_DIM
				&& w.pos_x < win_w && w.pos_y < win_h && wc.level != 8'd0;
			w_draw = w_hit && wc.layer < LAYER_LIMIT;
			w_lv = faded(wc.level);
		endfunction

		function void note_word(in_word_t w);
			bit m_hit, m_draw, w_hit, w_draw;
			logic [7:0] m_lv, w_lv;
			int mi;
			int wi;
			out_word_t px;
			mi = int'(w.pos_y) * MAIN_DIM + int'(w.pos_x);
			wi = int'(w.pos_y) * WINDOW_DIM + int'(w.pos_x);
			case (w.action)
				ACT_DECAY: begin
					decay_plan(w, m_hit, m_draw, m_lv, w_hit, w_draw, w_lv);
					px.pixel_x = w.pos_x;
					px.pixel_y = w.pos_y;
					if (m_hit) begin
						main_cells[mi].level = m_lv;
						if (m_draw) begin
							px.plane = PLANE_MAIN;
							px.pixel_color = main_pal[m_lv] ^
								(main_cells[mi].overlay_on ? main_cells[mi].overlay : 32'd0);
							px.last = !w_draw;
							pixel_writes.push_back(px);
						end
					end
					if (w_hit) begin
						win_cells[wi].level = w_lv;
						if (w_draw) begin
							px.plane = PLANE_WIN;
							px.pixel_color = win_pal[w_lv];
							px.last = 1'b1;
							pixel_writes.push_back(px);
						end
					end
				end
				ACT_WR_MAIN: if (w.pos_x < MAIN_DIM && w.pos_y < MAIN_DIM)
					main_cells[mi] = '{overlay: w.color_value, overlay_on: w.overlay_on,
						layer: w.layer_level, level: w.intensity};
				ACT_WR_WIN: if (w.pos_x < WINDOW_DIM && w.pos_y < WINDOW_DIM)
					win_cells[wi] = '{layer: w.layer_level, level: w.intensity};
				ACT_LD_MAIN: begin
					main_pal[w.intensity] = w.color_value;
					main_loaded[w.intensity] = 1'b1;
				end
				ACT_LD_WIN: begin
					win_pal[w.intensity] = w.color_value;
					win_loaded[w.intensity] = 1'b1;
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			if (errors < 40)
				$display("%0t ns  frame-buffer word mismatch: %s", $time, what);
			errors++;
		endtask

		task check_result(out_word_t got);
			out_word_t want;
			if (pixel_writes.size() == 0) begin
				report($sformatf("unexpected word %h", got));
				return;
			end
			want = pixel_writes.pop_front();
			checked++;
			if (got.plane !== want.plane)
				report($sformatf("plane %0d, want %0d", got.plane, want.plane));
			if (got.pixel_x !== want.pixel_x)
				report($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
			if (got.pixel_y !== want.pixel_y)
				report($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
			if (got.pixel_color !== want.pixel_color)
				report($sformatf("pixel_color %h, want %h", got.pixel_color, want.pixel_color));
			if (got.last !== want.last)
				report($sformatf("last %0d, want %0d", got.last, want.last));
		endtask

		function int pending();
			return pixel_writes.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_word_t    in_word   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_word;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = CFG_DECAY_WEIGHT;
	logic [10:0] cfg_data  = '0;

	pixel_scoreboard sb;
	bit steady;
	int words_sent;
	int decays_sent;
	int pool_x[POOL_SIZE];
	int pool_y[POOL_SIZE];

	radar_afterglow_pixel_decay_core #(
		.MAIN_DIM  (MAIN_DIM),
		.WINDOW_DIM(WINDOW_DIM)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(out_word);
		out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	task automatic pass_word(in_word_t w);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
		words_sent++;
	endtask

	task automatic load_palette(logic [2:0] act, logic [7:0] idx);
		in_word_t w;
		w = '0;
		w.action = act;
		w.intensity = idx;
		w.pos_x = 10'($urandom_range(0, 1023));
		w.pos_y = 10'($urandom_range(0, 1023));
		w.color_value = $urandom();
		pass_word(w);
	endtask

	// fill any palette entry the visit is about to read
	task automatic issue(in_word_t w);
		bit mh, md, wh, wd;
		logic [7:0] ml, wl;
		if (w.action == ACT_DECAY) begin
			sb.decay_plan(w, mh, md, ml, wh, wd, wl);
			if (md && !sb.main_loaded[ml])
				load_palette(ACT_LD_MAIN, ml);
			if (wd && !sb.win_loaded[wl])
				load_palette(ACT_LD_WIN, wl);
			decays_sent++;
		end
		pass_word(w);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [7:0] wt, logic [10:0] mw, logic [10:0] mh,
			logic [9:0] ww, logic [9:0] wh, bit we, bit pe);
		logic [2:0] regs[7];
		logic [10:0] vals[7];
		regs = '{CFG_DECAY_WEIGHT, CFG_MAIN_WIDTH, CFG_MAIN_HEIGHT, CFG_WIN_WIDTH,
			CFG_WIN_HEIGHT, CFG_WIN_ENABLE, CFG_PERSIST};
		vals = '{wt, mw, mh, ww, wh, we, pe};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic int near_limit(int lim);
		int v;
		v = lim - 1 + $urandom_range(0, 1);
		return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
	endfunction

	function automatic void build_pool(int mw, int mh, int ww, int wh);
		for (int i = 0; i < POOL_SIZE; i++) begin
			case (i % 4)
				0: begin
					pool_x[i] = $urandom_range(0, 3);
					pool_y[i] = $urandom_range(0, 3);
				end
				1: begin
					pool_x[i] = near_limit(mw);
					pool_y[i] = near_limit(mh);
				end
				2: begin
					pool_x[i] = near_limit(ww);
					pool_y[i] = near_limit(wh);
				end
				default: begin
					pool_x[i] = $urandom_range(0, WINDOW_DIM - 1);
					pool_y[i] = $urandom_range(0, MAIN_DIM - 1);
				end
			endcase
		end
	endfunction

	function automatic in_word_t mk(logic [2:0] act, logic [9:0] x, logic [9:0] y,
			logic [7:0] lv, logic [1:0] layer, bit ovl, logic [31:0] color);
		in_word_t w;
		w.action = act;
		w.pos_x = x;
		w.pos_y = y;
		w.intensity = lv;
		w.layer_level = layer;
		w.overlay_on = ovl;
		w.color_value = color;
		return w;
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		int r;
		int k;
		w.intensity = 8'($urandom_range(0, 255));
		w.layer_level = ($urandom_range(0, 99) < 70) ? 2'($urandom_range(0, 1))
			: 2'($urandom_range(2, 3));
		w.overlay_on = 1'($urandom_range(0, 1));
		w.color_value = $urandom();
		if ($urandom_range(0, 99) < 85) begin
			k = $urandom_range(0, POOL_SIZE - 1);
			w.pos_x = 10'(pool_x[k]);
			w.pos_y = 10'(pool_y[k]);
		end else begin
			w.pos_x = 10'($urandom_range(0, 1023));
			w.pos_y = 10'($urandom_range(0, 1023));
		end
		r = $urandom_range(0, 99);
		if (r < 45)
			w.action = ACT_DECAY;
		else if (r < 65)
			w.action = ACT_WR_MAIN;
		else if (r < 80)
			w.action = ACT_WR_WIN;
		else if (r < 88)
			w.action = ACT_LD_MAIN;
		else if (r < 96)
			w.action = ACT_LD_WIN;
		else
			w.action = 3'($urandom_range(ACT_LD_WIN + 1, ACT_SPARE_TOP));
		return w;
	endfunction

	task automatic run_phase(int n, logic [7:0] wt, int mw, int mh, int ww, int wh,
			bit we, bit pe);
		in_word_t w;
		int start;
		bit paused;
		paused = 1'b0;
		hold_until_drained();
		set_config(wt, 11'(mw), 11'(mh), 10'(ww), 10'(wh), we, pe);
		build_pool(mw, mh, ww, wh);
		start = words_sent;
		while (words_sent - start < n) begin
			w = random_word();
			issue(w);
			// hold the sender until the output side has fully drained
			if (!paused && words_sent - start >= n / 2) begin
				paused = 1'b1;
				hold_until_drained();
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		issue(mk(ACT_WR_MAIN, 3, 3, 200, 0, 0, $urandom()));
		issue(mk(ACT_DECAY, 3, 3, 0, 0, 0, 0));
		hold_until_drained();
		set_config(60, 1024, 1024, 512, 512, 1, 1);
		issue(mk(ACT_LD_MAIN, 0, 0, 0, 0, 0, 32'hffff_ffff));
		issue(mk(ACT_LD_WIN, 1023, 1023, 255, 3, 1, 32'h0000_0000));
		issue(mk(ACT_WR_MAIN, 0, 0, 255, 0, 1, 32'hffff_ffff));
		issue(mk(ACT_WR_WIN, 0, 0, 255, 1, 0, 0));
		issue(mk(ACT_DECAY, 0, 0, 0, 0, 0, 0));
		issue(mk(ACT_WR_MAIN, 1023, 1023, 61, 1, 0, 32'h5a5a_a5a5));
		issue(mk(ACT_DECAY, 1023, 1023, 255, 3, 1, 32'hffff_ffff));
		issue(mk(ACT_WR_WIN, 511, 511, 30, 0, 0, 0));
		issue(mk(ACT_DECAY, 511, 511, 0, 0, 0, 0));
		issue(mk(ACT_DECAY, 5, 5, 0, 0, 0, 0));
		issue(mk(ACT_WR_MAIN, 7, 9, 100, 2, 1, $urandom()));
		issue(mk(ACT_WR_WIN, 7, 9, 100, 3, 0, 0));
		issue(mk(ACT_DECAY, 7, 9, 0, 0, 0, 0));
		issue(mk(ACT_DECAY, 7, 9, 0, 0, 0, 0));
		issue(mk(ACT_WR_WIN, 512, 0, 90, 0, 0, 0));
		issue(mk(ACT_WR_WIN, 0, 1023, 90, 0, 0, 0));
		issue(mk(ACT_DECAY, 512, 0, 0, 0, 0, 0));
		issue(mk(ACT_DECAY, 0, 1023, 0, 0, 0, 0));
		for (int a = ACT_LD_WIN + 1; a <= ACT_SPARE_TOP; a++)
			issue(mk(3'(a), 3, 3, 8'($urandom()), 2'(a), 1, $urandom()));
		issue(mk(ACT_DECAY, 3, 3, 0, 0, 0, 0));

		steady = 1'b1;
		run_phase(70, 8'($urandom_range(1, 80)), 1024, 1024, 512, 512, 1, 1);
		steady = 1'b0;
		run_phase(80, 255, 1024, 1024, 512, 512, 1, 1);
		run_phase(80, 0, 5, 7, 3, 4, 1, 1);
		run_phase(80, 8'($urandom_range(1, 80)), 0, 1024, 512, 512, 1, 1);
		run_phase(80, 8'($urandom_range(1, 80)), 1024, 1024, 0, 512, 1, 1);
		run_phase(80, 8'($urandom_range(1, 80)), 1024, 1024, 512, 0, 0, 1);
		run_phase(40, 8'($urandom_range(1, 80)), 1024, 0, 512, 512, 1, 0);
		run_phase(70, 8'($urandom_range(1, 80)), 700, 300, 200, 100, 1, 1);
		hold_until_drained();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d frame-buffer words never arrived", sb.pending()));

		$display("Sent %0d words (%0d decay visits) over eight register settings;",
			words_sent, decays_sent);
		$display("%0d pixel writes checked across both planes, layer and overlay paths,",
			sb.checked);
		$display("zero and full display limits, weights 0 and 255.");
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/rapd_pkg.sv
design/rapd_ram.sv
design/radar_afterglow_pixel_decay_core.sv
design/rapd_checker.sv
dv/tb_radar_afterglow_pixel_decay_core.sv
